// ----- rtl/qvp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the quintic velocity profile block: opcodes, fixed-point constants.
// No dependencies; imported by quintic_velocity_profile and qvp_checker.
package qvp_pkg;

   localparam int FRAC_BITS = 16;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_CHECK = 2'd3;

   localparam logic [31:0] EPS_RAW     = 32'd66;
   localparam logic [47:0] MIN_DUR     = 48'd78643;
   localparam logic [63:0] DUR_MAX     = 64'hFFFF_FFFF_FFFF;
   localparam logic [31:0] TOL_RESET   = 32'd66;
   localparam logic [16:0] ONE_Q       = 17'h10000;
   localparam logic [33:0] MS_PER_SEC  = 34'd1000;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 40;

   typedef logic [REQ_DATA_W-1:0] req_data_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;

endpackage

// ----- rtl/quintic_velocity_profile.sv -----
`timescale 1ns / 1ps
// Quintic velocity profile planner with shared bit-serial multiplier, divider, square root.
// Depends on qvp_pkg.
// After a word is accepted: clear and idle tick go straight to S_DONE, check through S_CHECK;
// a running tick steps S_TMUL through S_TDIVV in turn; an expired tick stops after S_TMUL.
// Start steps S_MX, S_MY, S_SQRT, S_DDUR; a short move or zero speed limit skips S_DDUR.
// One word in work at a time: next word taken in the cycle after its result is registered,
// also while that result waits. Reset clears the plan, speed limit to 0, tolerance to 66.
module quintic_velocity_profile (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  qvp_pkg::req_data_type req_tdata,  // start_x, start_y, dest_x, dest_y, now_ms
   input  logic [1:0]            req_tuser,  // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output qvp_pkg::rsp_data_type rsp_tdata,  // velocity, active, replan, zero pad
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata
);
   import qvp_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MX    = 4'd1;
   localparam logic [3:0] S_MY    = 4'd2;
   localparam logic [3:0] S_SQRT  = 4'd3;
   localparam logic [3:0] S_DDUR  = 4'd4;
   localparam logic [3:0] S_TMUL  = 4'd5;
   localparam logic [3:0] S_TDIVU = 4'd6;
   localparam logic [3:0] S_TW    = 4'd7;
   localparam logic [3:0] S_TP    = 4'd8;
   localparam logic [3:0] S_TV    = 4'd9;
   localparam logic [3:0] S_TDIVV = 4'd10;
   localparam logic [3:0] S_CHECK = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic [31:0] spd_lim_ff, spd_lim_in, tol_ff, tol_in;
   logic [31:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in, begin_ff, begin_in;
   logic [33:0] path_ff, path_in;
   logic [47:0] dur_ff, dur_in;
   logic        running_ff, running_in;

   logic [31:0] tx_ff, tx_in, ty_ff, ty_in, now_ff, now_in;
   logic [32:0] ay_ff, ay_in;
   logic [65:0] sum_ff, sum_in;
   logic [31:0] vel_ff, vel_in;
   logic        rep_ff, rep_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [65:0] mul_a_ff, mul_a_in, mul_p_ff, mul_p_in;
   logic [33:0] mul_b_ff, mul_b_in;
   logic [59:0] div_r_ff, div_r_in;
   logic [63:0] div_n_ff, div_n_in, div_q_ff, div_q_in;
   logic [57:0] div_d_ff, div_d_in;
   logic [65:0] sq_rad_ff, sq_rad_in;
   logic [35:0] sq_rem_ff, sq_rem_in;
   logic [32:0] sq_root_ff, sq_root_in;

   logic [31:0] in_sx, in_sy, in_tx, in_ty;
   logic [32:0] dx, dy, ax, ay, gdx, gdy, gmx, gmy;
   logic [65:0] mul_p_step;
   logic [60:0] div_rs;
   logic        div_ge;
   logic [35:0] sq_r2;
   logic [34:0] sq_trial;
   logic        sq_ge;
   logic [36:0] dist15;
   logic [47:0] elapsed;
   logic [29:0] ww;
   logic [34:0] p30;
   logic [31:0] tol_eff;
   logic        step_done;

   assign in_sx = req_tdata[31:0];
   assign in_sy = req_tdata[63:32];
   assign in_tx = req_tdata[95:64];
   assign in_ty = req_tdata[127:96];

   always_comb begin
      dx  = {in_tx[31], in_tx} - {in_sx[31], in_sx};
      dy  = {in_ty[31], in_ty} - {in_sy[31], in_sy};
      ax  = dx[32] ? (33'd0 - dx) : dx;
      ay  = dy[32] ? (33'd0 - dy) : dy;
      gdx = {goal_x_ff[31], goal_x_ff} - {tx_ff[31], tx_ff};
      gdy = {goal_y_ff[31], goal_y_ff} - {ty_ff[31], ty_ff};
      gmx = gdx[32] ? (33'd0 - gdx) : gdx;
      gmy = gdy[32] ? (33'd0 - gdy) : gdy;
      tol_eff = (tol_ff == 32'd0) ? EPS_RAW : tol_ff;
      mul_p_step = mul_b_ff[0] ? (mul_p_ff + mul_a_ff) : mul_p_ff;
      div_rs = {div_r_ff, div_n_ff[63]};
      div_ge = div_rs >= {3'b000, div_d_ff};
      sq_r2 = {sq_rem_ff[33:0], sq_rad_ff[65:64]};
      sq_trial = {sq_root_ff, 2'b01};
      sq_ge = sq_r2 >= {1'b0, sq_trial};
      dist15 = {sq_root_ff, 4'b0000} - {4'b0000, sq_root_ff};
      elapsed = {now_ff - begin_ff, 16'h0000};
      ww = mul_p_ff[29:0];
      p30 = {ww, 5'b00000} - {4'b0000, ww, 1'b0};
      step_done = (cnt_ff == 7'd0);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      spd_lim_in   = spd_lim_ff;
      tol_in       = tol_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      begin_in     = begin_ff;
      path_in      = path_ff;
      dur_in       = dur_ff;
      running_in   = running_ff;
      tx_in = tx_ff; ty_in = ty_ff; now_in = now_ff; ay_in = ay_ff;
      sum_in = sum_ff; vel_in = vel_ff; rep_in = rep_ff;
      cnt_in = cnt_ff;
      mul_a_in = mul_a_ff; mul_b_in = mul_b_ff; mul_p_in = mul_p_ff;
      div_r_in = div_r_ff; div_n_in = div_n_ff; div_q_in = div_q_ff; div_d_in = div_d_ff;
      sq_rad_in = sq_rad_ff; sq_rem_in = sq_rem_ff; sq_root_in = sq_root_ff;

      if (csr_we) begin
         if (csr_index) tol_in = csr_wdata;
         else           spd_lim_in = csr_wdata;
      end

      // advance whichever serial unit the state owns
      if (!step_done) begin
         cnt_in = cnt_ff - 7'd1;
         unique case (state_ff)
            S_MX, S_MY, S_TMUL, S_TW, S_TP, S_TV: begin
               mul_p_in = mul_p_step;
               mul_a_in = {mul_a_ff[64:0], 1'b0};
               mul_b_in = {1'b0, mul_b_ff[33:1]};
            end
            S_DDUR, S_TDIVU, S_TDIVV: begin
               div_r_in = div_ge ? 60'(div_rs - {3'b000, div_d_ff}) : div_rs[59:0];
               div_n_in = {div_n_ff[62:0], 1'b0};
               div_q_in = {div_q_ff[62:0], div_ge};
            end
            S_SQRT: begin
               sq_rem_in  = sq_ge ? (sq_r2 - {1'b0, sq_trial}) : sq_r2;
               sq_root_in = {sq_root_ff[31:0], sq_ge};
               sq_rad_in  = {sq_rad_ff[63:0], 2'b00};
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               tx_in  = in_tx;
               ty_in  = in_ty;
               now_in = req_tdata[159:128];
               vel_in = 32'd0;
               rep_in = 1'b0;
               unique case (req_tuser)
                  OP_CLEAR: begin
                     goal_x_in = '0; goal_y_in = '0; begin_in = '0;
                     path_in = '0; dur_in = '0; running_in = 1'b0;
                     state_in = S_DONE;
                  end
                  OP_START: begin
                     ay_in = ay;
                     mul_a_in = {33'd0, ax};
                     mul_b_in = {1'b0, ax};
                     mul_p_in = '0;
                     cnt_in = 7'd33;
                     state_in = S_MX;
                  end
                  OP_TICK: begin
                     if (!running_ff || spd_lim_ff == 32'd0) begin
                        state_in = S_DONE;
                     end else begin
                        mul_a_in = {18'd0, dur_ff};
                        mul_b_in = MS_PER_SEC;
                        mul_p_in = '0;
                        cnt_in = 7'd10;
                        state_in = S_TMUL;
                     end
                  end
                  default: state_in = S_CHECK;
               endcase
            end
         end
         S_MX: if (step_done) begin
            sum_in = mul_p_ff;
            mul_a_in = {33'd0, ay_ff};
            mul_b_in = {1'b0, ay_ff};
            mul_p_in = '0;
            cnt_in = 7'd33;
            state_in = S_MY;
         end
         S_MY: if (step_done) begin
            sq_rad_in = sum_ff + mul_p_ff;
            sq_rem_in = '0;
            sq_root_in = '0;
            cnt_in = 7'd33;
            state_in = S_SQRT;
         end
         S_SQRT: if (step_done) begin
            goal_x_in = tx_ff;
            goal_y_in = ty_ff;
            path_in = {1'b0, sq_root_ff};
            begin_in = now_ff;
            if (sq_root_ff <= {1'b0, EPS_RAW} || spd_lim_ff == 32'd0) begin
               dur_in = MIN_DUR;
               running_in = 1'b0;
               state_in = S_DONE;
            end else begin
               div_r_in = '0;
               div_n_in = {11'd0, dist15, 16'h0000};
               div_d_in = {23'd0, spd_lim_ff, 3'b000};
               div_q_in = '0;
               cnt_in = 7'd64;
               state_in = S_DDUR;
            end
         end
         S_DDUR: if (step_done) begin
            if (div_q_ff > DUR_MAX)                dur_in = DUR_MAX[47:0];
            else if (div_q_ff[47:0] < MIN_DUR)     dur_in = MIN_DUR;
            else                                   dur_in = div_q_ff[47:0];
            running_in = 1'b1;
            state_in = S_DONE;
         end
         S_TMUL: if (step_done) begin
            if ({10'd0, elapsed} >= mul_p_ff[57:0]) begin
               running_in = 1'b0;
               state_in = S_DONE;
            end else begin
               div_r_in = {12'd0, elapsed};
               div_n_in = '0;
               div_d_in = mul_p_ff[57:0];
               div_q_in = '0;
               cnt_in = 7'd16;
               state_in = S_TDIVU;
            end
         end
         S_TDIVU: if (step_done) begin
            mul_a_in = {50'd0, div_q_ff[15:0]};
            mul_b_in = {17'd0, ONE_Q - {1'b0, div_q_ff[15:0]}};
            mul_p_in = '0;
            cnt_in = 7'd17;
            state_in = S_TW;
         end
         S_TW: if (step_done) begin
            mul_a_in = {51'd0, mul_p_ff[30:16]};
            mul_b_in = {19'd0, mul_p_ff[30:16]};
            mul_p_in = '0;
            cnt_in = 7'd15;
            state_in = S_TP;
         end
         S_TP: if (step_done) begin
            mul_a_in = {32'd0, path_ff};
            mul_b_in = {15'd0, p30[34:16]};
            mul_p_in = '0;
            cnt_in = 7'd19;
            state_in = S_TV;
         end
         S_TV: if (step_done) begin
            div_r_in = '0;
            div_n_in = mul_p_ff[63:0];
            div_d_in = {10'd0, dur_ff};
            div_q_in = '0;
            cnt_in = 7'd64;
            state_in = S_TDIVV;
         end
         S_TDIVV: if (step_done) begin
            vel_in = (div_q_ff > {32'd0, spd_lim_ff}) ? spd_lim_ff : div_q_ff[31:0];
            state_in = S_DONE;
         end
         S_CHECK: begin
            rep_in = !running_ff || (gmx > {1'b0, tol_eff}) || (gmy > {1'b0, tol_eff});
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'd0, rep_ff, running_ff, vel_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         spd_lim_ff   <= 32'd0;
         tol_ff       <= TOL_RESET;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         begin_ff     <= '0;
         path_ff      <= '0;
         dur_ff       <= '0;
         running_ff   <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         spd_lim_ff   <= spd_lim_in;
         tol_ff       <= tol_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         begin_ff     <= begin_in;
         path_ff      <= path_in;
         dur_ff       <= dur_in;
         running_ff   <= running_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      tx_ff <= tx_in;
      ty_ff <= ty_in;
      now_ff <= now_in;
      ay_ff <= ay_in;
      sum_ff <= sum_in;
      vel_ff <= vel_in;
      rep_ff <= rep_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      mul_p_ff <= mul_p_in;
      div_r_ff <= div_r_in;
      div_n_ff <= div_n_in;
      div_q_ff <= div_q_in;
      div_d_ff <= div_d_in;
      sq_rad_ff <= sq_rad_in;
      sq_rem_ff <= sq_rem_in;
      sq_root_ff <= sq_root_in;
   end

endmodule

// ----- rtl/qvp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for quintic_velocity_profile, bound to the top level.
// Depends on qvp_pkg.
module qvp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input qvp_pkg::rsp_data_type rsp_tdata
);
   import qvp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word right after reset");

   a_replan_no_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[31:0] == 32'd0)
      else $error("replan word carries a velocity");

   a_vel_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:0] != 32'd0 |-> rsp_tdata[32])
      else $error("velocity without an active plan");

endmodule

bind quintic_velocity_profile qvp_checker u_qvp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/quintic_velocity_profile_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for quintic_velocity_profile: directed opcode and corner cases,
// register sweeps and random plan sequences scored against an in-bench profile predictor.
// Depends on qvp_pkg and the quintic_velocity_profile RTL.
module quintic_velocity_profile_tb;
   import qvp_pkg::*;

   localparam logic      REG_SPEED_LIM = 1'b0;
   localparam logic      REG_TOLERANCE = 1'b1;
   localparam int        CYCLE_LIMIT   = 3000000;
   localparam int        SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [31:0] velocity;
      logic        active;
      logic        replan;
   } profile_out_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   req_data_type req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   rsp_data_type rsp_tdata;
   logic         csr_we;
   logic         csr_index;
   logic [31:0]  csr_wdata;

   // predictor copy of registers and plan
   logic [31:0]        lim_speed;
   logic [31:0]        tol_reg;
   logic signed [31:0] goal_x;
   logic signed [31:0] goal_y;
   logic [33:0]        path_len;
   logic [47:0]        plan_dur;
   logic [31:0]        begin_t;
   logic               running;

   profile_out_t expected_q[$];
   int           fail_count;
   int           word_count;
   int           setting_count;
   int           burst_left;
   int           cycle_count;
   int           stall_mode;

   quintic_velocity_profile dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] root_floor(input logic [127:0] val);
      logic [127:0] root;
      logic [127:0] rem;
      logic [127:0] trial;
      root = '0;
      rem  = '0;
      for (int i = 63; i >= 0; i--) begin
         rem   = (rem << 2) | ((val >> (2 * i)) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic logic [63:0] abs_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic signed [63:0] d;
      d = 64'(a) - 64'(b);
      return d < 0 ? -d : d;
   endfunction

   function automatic profile_out_t plan_step(input logic [1:0] op,
                                              input logic signed [31:0] sx,
                                              input logic signed [31:0] sy,
                                              input logic signed [31:0] tx,
                                              input logic signed [31:0] ty,
                                              input logic [31:0] now);
      profile_out_t  res;
      logic [63:0]   ax, ay, tol;
      logic [127:0]  quo, el, dn, u, w, p;
      res = '0;
      case (op)
         OP_CLEAR: begin
            goal_x = 0; goal_y = 0; path_len = 0; plan_dur = 0; begin_t = 0;
            running = 1'b0;
         end
         OP_START: begin
            ax = abs_diff(tx, sx);
            ay = abs_diff(ty, sy);
            path_len = 34'(root_floor(128'(ax) * ax + 128'(ay) * ay));
            goal_x = tx; goal_y = ty; begin_t = now;
            if (path_len <= 34'(EPS_RAW) || lim_speed == 0) begin
               plan_dur = MIN_DUR;
               running  = 1'b0;
            end else begin
               quo = (128'(path_len) * 15 * 65536) / (128'(lim_speed) * 8);
               if (quo > 128'(DUR_MAX)) quo = 128'(DUR_MAX);
               if (quo < 128'(MIN_DUR)) quo = 128'(MIN_DUR);
               plan_dur = quo[47:0];
               running  = 1'b1;
            end
         end
         OP_TICK: begin
            if (running && lim_speed != 0) begin
               el = 128'(32'(now - begin_t)) << FRAC_BITS;
               dn = 128'(plan_dur) * 1000;
               if (el >= dn) begin
                  running = 1'b0;
               end else begin
                  u   = (el << FRAC_BITS) / dn;
                  w   = (u * (128'(ONE_Q) - u)) >> FRAC_BITS;
                  p   = (30 * w * w) >> FRAC_BITS;
                  quo = (p * path_len) / plan_dur;
                  if (quo > 128'(lim_speed)) quo = 128'(lim_speed);
                  res.velocity = quo[31:0];
               end
            end
         end
         default: begin
            tol = (tol_reg == 0) ? 64'(EPS_RAW) : 64'(tol_reg);
            res.replan = !running || abs_diff(goal_x, tx) > tol || abs_diff(goal_y, ty) > tol;
         end
      endcase
      res.active = running;
      return res;
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] now);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {now, ty, tx, sy, sx};
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(plan_step(op, sx, sy, tx, ty, now));
      word_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (idx == REG_SPEED_LIM) lim_speed = val;
      else tol_reg = val;
   endtask

   function automatic logic [31:0] tick_time();
      logic [63:0] span;
      span = (64'(plan_dur) * 1000) >> FRAC_BITS;
      span = span + span / 10 + 2;
      return begin_t + 32'({$urandom, $urandom} % span);
   endfunction

   task automatic test_directed();
      send_word(OP_CHECK, 0, 0, 0, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 0, 32'd5);
      send_word(OP_START, 0, 0, 32'h0010_0000, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 0, 32'd10);
      drain();
      write_reg(REG_SPEED_LIM, 32'h0001_0000);
      send_word(OP_START, 0, 0, 32'd66, 0, 32'd100);
      send_word(OP_CHECK, 0, 0, 32'd66, 0, 0);
      send_word(OP_START, 0, 0, 32'd67, 0, 32'hFFFF_FFF0);
      send_word(OP_TICK, 0, 0, 0, 0, 32'd20);
      send_word(OP_TICK, 0, 0, 0, 0, 32'd1184);
      send_word(OP_START, 32'h0000_0000, 0, 32'h000A_0000, 0, 32'd1000);
      send_word(OP_TICK, 0, 0, 0, 0, 32'd10375);
      send_word(OP_CHECK, 0, 0, 32'h000A_0042, 32'hFFFF_FFBE, 0);
      send_word(OP_CHECK, 0, 0, 32'h000A_0043, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 0, 32'd19750);
      send_word(OP_TICK, 0, 0, 0, 0, 32'd19751);
      send_word(OP_START, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'hFFFF_FFFF);
      send_word(OP_TICK, 0, 0, 0, 0, 32'h7FFF_FFFF);
      send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      send_word(OP_TICK, 0, 0, 0, 0, 0);
      drain();
      write_reg(REG_SPEED_LIM, 32'hFFFF_FFFF);
      write_reg(REG_TOLERANCE, 32'd0);
      send_word(OP_START, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h0040_0000, 32'd7);
      send_word(OP_TICK, 0, 0, 0, 0, tick_time());
      send_word(OP_CHECK, 0, 0, 32'h8000_0042, 32'h0040_0000, 0);
      drain();
      setting_count += 3;
   endtask

   task automatic random_plans(input int n_words);
      logic [31:0] sx, sy, tx, ty;
      int          sel;
      while (n_words > 0) begin
         sel = $urandom_range(0, 99);
         if (sel < 15) begin
            send_word(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
            n_words--;
         end else begin
            sx = $urandom; sy = $urandom;
            case ($urandom_range(0, 3))
               0: begin tx = sx + $urandom_range(0, 140) - 70; ty = sy; end
               1: begin tx = $urandom; ty = $urandom; end
               default: begin
                  tx = sx + $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
                  ty = sy + $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
               end
            endcase
            send_word(OP_START, sx, sy, tx, ty, $urandom);
            n_words--;
            repeat ($urandom_range(2, 10)) begin
               if ($urandom_range(0, 3) == 0)
                  send_word(OP_CHECK, $urandom, $urandom,
                            goal_x + $urandom_range(0, 200) - 100,
                            goal_y + $urandom_range(0, 200) - 100, $urandom);
               else
                  send_word(OP_TICK, $urandom, $urandom, $urandom, $urandom, tick_time());
               n_words--;
            end
            if ($urandom_range(0, 4) == 0) begin
               send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
               n_words--;
            end
         end
      end
      drain();
   endtask

   task automatic test_register_sweep();
      logic [31:0] speeds[6];
      logic [31:0] tols[6];
      speeds = '{32'd0, 32'd1, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0100_0000};
      tols   = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd66, 32'd200, 32'h0001_0000};
      for (int i = 0; i < 6; i++) begin
         write_reg(REG_SPEED_LIM, speeds[i]);
         write_reg(REG_TOLERANCE, tols[i]);
         setting_count++;
         random_plans(60);
      end
   endtask

   task automatic test_random();
      for (int i = 0; i < 10; i++) begin
         write_reg(REG_SPEED_LIM, ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 32'h4_0000));
         write_reg(REG_TOLERANCE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 300));
         setting_count++;
         random_plans(85);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 500 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quintic_velocity_profile_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      profile_out_t want;
      profile_out_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[33]};
         if (expected_q.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (got.velocity !== want.velocity) begin
               $error("velocity: expected %0d actual %0d", want.velocity, got.velocity);
               fail_count++;
            end
            if (got.active !== want.active) begin
               $error("active: expected %0d actual %0d", want.active, got.active);
               fail_count++;
            end
            if (got.replan !== want.replan) begin
               $error("replan: expected %0d actual %0d", want.replan, got.replan);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = OP_CLEAR;
      rsp_tready = 1'b0; csr_we = 1'b0; csr_index = REG_SPEED_LIM; csr_wdata = '0;
      fail_count = 0; word_count = 0; setting_count = 1; burst_left = 0;
      cycle_count = 0; stall_mode = 0;
      lim_speed = 0; tol_reg = TOL_RESET;
      goal_x = 0; goal_y = 0; path_len = 0; plan_dur = 0; begin_t = 0; running = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_sweep();
      test_random();
      if (expected_q.size() != 0) begin
         $error("%0d result words never arrived", expected_q.size());
         fail_count++;
      end
      $display("Sent %0d words across %0d register settings: clear, start, tick and check,",
               word_count, setting_count);
      $display("with short, long and saturating plans under random stalls on both sides.");
      if (fail_count == 0)
         $display("quintic_velocity_profile_tb OK");
      else
         $display("quintic_velocity_profile_tb NOT OK");
      $finish;
   end

endmodule
